// ===== rtl/bhp_pkg.sv =====
// bhp_pkg: sizes, payload structs, the state encoding and the sign extension helper
// used throughout the balanced half partition block. No dependencies.
package bhp_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int VALUE_W   = 16;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    // holds half sums, their difference and every intermediate of the swap test
    localparam int SUM_W     = VALUE_W + $clog2(MAX_ITEMS) + 1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      half;
        logic                      last_res;
    } result_t;

    typedef struct packed {
        logic                      we;
        logic [ADDR_W-1:0]         waddr;
        logic signed [VALUE_W-1:0] wdata;
        logic [ADDR_W-1:0]         raddr0;
        logic [ADDR_W-1:0]         raddr1;
    } mem_req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic                    sub;
    } alu_op_t;

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_SORT_RD  = 16'h0002,
        S_SORT_CMP = 16'h0004,
        S_SORT_WR  = 16'h0008,
        S_SUM_RD   = 16'h0010,
        S_SUM_A    = 16'h0020,
        S_SUM_B    = 16'h0040,
        S_SUM_ABS  = 16'h0080,
        S_SW_RD    = 16'h0100,
        S_SW_DELTA = 16'h0200,
        S_SW_CAND  = 16'h0400,
        S_SW_ABS   = 16'h0800,
        S_SW_CMP   = 16'h1000,
        S_SW_WR    = 16'h2000,
        S_EM_RD    = 16'h4000,
        S_EM_OUT   = 16'h8000
    } state_t;

    function automatic logic signed [SUM_W-1:0] sext(input logic signed [VALUE_W-1:0] x);
        return {{(SUM_W - VALUE_W){x[VALUE_W-1]}}, x};
    endfunction

endpackage

// ===== rtl/balanced_half_partition.sv =====
// balanced_half_partition: collects a set, sorts it, balances two halves by greedy swaps
// depends on bhp_pkg, bhp_store and bhp_alu
//
//  channel   signals                               direction
//  item      item_valid / item_ready / item         in  (value, last)
//  result    result_valid / result_ready / result   out (value_res, half, last_res)
//
// loading: one item per cycle; the item with last set starts the processing
// after last with n stored and m = n/2: a bubble sort of n(n-1)/2 compares,
// the half sums, a swap test for each of the m*m pairs, then the results;
// all of it paced by the single shared adder and the one write port of the
// element memory
// reset clears the sequencer and the fill count; the memory is not cleared
// item_ready is low from the last item until the final result is in the output register, except after a set of one

module balanced_half_partition (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  bhp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output bhp_pkg::result_t result
);

    localparam int AW = bhp_pkg::ADDR_W;
    localparam int CW = bhp_pkg::CNT_W;
    localparam int SW = bhp_pkg::SUM_W;
    localparam int VW = bhp_pkg::VALUE_W;

    bhp_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] lim_reg, lim_next;
    logic [AW-1:0] q_reg, q_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;

    bhp_pkg::result_t     out_reg, out_next;
    logic signed [SW-1:0] diff_reg, diff_next;
    logic signed [SW-1:0] delta_reg, delta_next;
    logic signed [SW-1:0] cand_reg, cand_next;
    logic signed [SW-1:0] absc_reg, absc_next;
    logic signed [SW-1:0] best_reg, best_next;
    logic signed [VW-1:0] av_reg, av_next;
    logic signed [VW-1:0] bv_reg, bv_next;

    bhp_pkg::mem_req_t    mem_req;
    logic signed [VW-1:0] rd0;
    logic signed [VW-1:0] rd1;
    bhp_pkg::alu_op_t     alu_op;
    logic signed [SW-1:0] alu_sum;
    logic                 alu_neg;

    logic          full;
    logic [CW-1:0] cnt_new;
    logic [AW-1:0] m_last;
    logic          emit_last;

    bhp_store u_store (
        .clk    (clk),
        .req    (mem_req),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    bhp_alu u_alu (
        .op  (alu_op),
        .sum (alu_sum)
    );

    assign alu_neg   = alu_sum[SW-1];
    assign full      = (count_reg == CW'(bhp_pkg::MAX_ITEMS));
    assign cnt_new   = full ? count_reg : count_reg + CW'(1);
    assign m_last    = m_reg - AW'(1);
    assign emit_last = ((CW'(k_reg) + CW'(1)) == (CW'(m_reg) << 1));

    assign item_ready   = (state_reg == bhp_pkg::S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        m_next         = m_reg;
        lim_next       = lim_reg;
        q_next         = q_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        diff_next      = diff_reg;
        delta_next     = delta_reg;
        cand_next      = cand_reg;
        absc_next      = absc_reg;
        best_next      = best_reg;
        av_next        = av_reg;
        bv_next        = bv_reg;

        mem_req.we     = 1'b0;
        mem_req.waddr  = q_reg;
        mem_req.wdata  = rd1;
        mem_req.raddr0 = q_reg;
        mem_req.raddr1 = q_reg + AW'(1);

        alu_op.a   = diff_reg;
        alu_op.b   = bhp_pkg::sext(rd0);
        alu_op.sub = 1'b0;

        case (state_reg)
            bhp_pkg::S_IDLE:
            begin
                mem_req.waddr = count_reg[AW-1:0];
                mem_req.wdata = item.value;
                if (item_valid)
                begin
                    mem_req.we = !full;
                    count_next = cnt_new;
                    if (item.last)
                    begin
                        m_next    = AW'(cnt_new >> 1);
                        lim_next  = AW'(cnt_new - CW'(1));
                        q_next    = '0;
                        diff_next = '0;
                        if ((cnt_new >> 1) == '0)
                        begin
                            // set of one: nothing to emit
                            count_next = '0;
                        end
                        else
                        begin
                            state_next = bhp_pkg::S_SORT_RD;
                        end
                    end
                end
            end

            bhp_pkg::S_SORT_RD:
            begin
                state_next = bhp_pkg::S_SORT_CMP;
            end

            bhp_pkg::S_SORT_CMP, bhp_pkg::S_SORT_WR:
            begin
                alu_op.a   = bhp_pkg::sext(rd1);
                alu_op.b   = bhp_pkg::sext(rd0);
                alu_op.sub = 1'b1;
                if (state_reg == bhp_pkg::S_SORT_CMP && alu_neg)
                begin
                    // neighbours out of order: lower slot first, upper next cycle
                    mem_req.we    = 1'b1;
                    mem_req.waddr = q_reg;
                    mem_req.wdata = rd1;
                    av_next       = rd0;
                    state_next    = bhp_pkg::S_SORT_WR;
                end
                else
                begin
                    if (state_reg == bhp_pkg::S_SORT_WR)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = q_reg + AW'(1);
                        mem_req.wdata = av_reg;
                    end
                    if (q_reg + AW'(1) == lim_reg)
                    begin
                        q_next   = '0;
                        lim_next = lim_reg - AW'(1);
                        if (lim_reg == AW'(1))
                        begin
                            i_next     = '0;
                            state_next = bhp_pkg::S_SUM_RD;
                        end
                        else
                        begin
                            state_next = bhp_pkg::S_SORT_RD;
                        end
                    end
                    else
                    begin
                        q_next     = q_reg + AW'(1);
                        state_next = bhp_pkg::S_SORT_RD;
                    end
                end
            end

            bhp_pkg::S_SUM_RD:
            begin
                mem_req.raddr0 = i_reg;
                mem_req.raddr1 = m_reg + i_reg;
                state_next     = bhp_pkg::S_SUM_A;
            end

            bhp_pkg::S_SUM_A:
            begin
                alu_op.a   = diff_reg;
                alu_op.b   = bhp_pkg::sext(rd0);
                diff_next  = alu_sum;
                bv_next    = rd1;
                state_next = bhp_pkg::S_SUM_B;
            end

            bhp_pkg::S_SUM_B:
            begin
                alu_op.a   = diff_reg;
                alu_op.b   = bhp_pkg::sext(bv_reg);
                alu_op.sub = 1'b1;
                diff_next  = alu_sum;
                if (i_reg == m_last)
                begin
                    state_next = bhp_pkg::S_SUM_ABS;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = bhp_pkg::S_SUM_RD;
                end
            end

            bhp_pkg::S_SUM_ABS:
            begin
                alu_op.a   = '0;
                alu_op.b   = diff_reg;
                alu_op.sub = diff_reg[SW-1];
                best_next  = alu_sum;
                i_next     = '0;
                j_next     = '0;
                state_next = bhp_pkg::S_SW_RD;
            end

            bhp_pkg::S_SW_RD:
            begin
                mem_req.raddr0 = i_reg;
                mem_req.raddr1 = m_reg + j_reg;
                state_next     = bhp_pkg::S_SW_DELTA;
            end

            bhp_pkg::S_SW_DELTA:
            begin
                alu_op.a   = bhp_pkg::sext(rd1);
                alu_op.b   = bhp_pkg::sext(rd0);
                alu_op.sub = 1'b1;
                delta_next = alu_sum;
                av_next    = rd0;
                bv_next    = rd1;
                state_next = bhp_pkg::S_SW_CAND;
            end

            bhp_pkg::S_SW_CAND:
            begin
                // a - b after the swap moves by twice the exchanged difference
                alu_op.a   = diff_reg;
                alu_op.b   = {delta_reg[SW-2:0], 1'b0};
                cand_next  = alu_sum;
                state_next = bhp_pkg::S_SW_ABS;
            end

            bhp_pkg::S_SW_ABS:
            begin
                alu_op.a   = '0;
                alu_op.b   = cand_reg;
                alu_op.sub = cand_reg[SW-1];
                absc_next  = alu_sum;
                state_next = bhp_pkg::S_SW_CMP;
            end

            bhp_pkg::S_SW_CMP, bhp_pkg::S_SW_WR:
            begin
                alu_op.a   = absc_reg;
                alu_op.b   = best_reg;
                alu_op.sub = 1'b1;
                if (state_reg == bhp_pkg::S_SW_CMP && alu_neg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = i_reg;
                    mem_req.wdata = bv_reg;
                    diff_next     = cand_reg;
                    best_next     = absc_reg;
                    state_next    = bhp_pkg::S_SW_WR;
                end
                else
                begin
                    if (state_reg == bhp_pkg::S_SW_WR)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = m_reg + j_reg;
                        mem_req.wdata = av_reg;
                    end
                    if (j_reg == m_last)
                    begin
                        j_next = '0;
                        if (i_reg == m_last)
                        begin
                            k_next     = '0;
                            state_next = bhp_pkg::S_EM_RD;
                        end
                        else
                        begin
                            i_next     = i_reg + AW'(1);
                            state_next = bhp_pkg::S_SW_RD;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + AW'(1);
                        state_next = bhp_pkg::S_SW_RD;
                    end
                end
            end

            bhp_pkg::S_EM_RD:
            begin
                mem_req.raddr0 = k_reg;
                // wait for room in the output register
                if (!out_valid_reg || result_ready)
                begin
                    state_next = bhp_pkg::S_EM_OUT;
                end
            end

            bhp_pkg::S_EM_OUT:
            begin
                mem_req.raddr0     = k_reg;
                out_next.value_res = rd0;
                out_next.half      = (k_reg >= m_reg);
                out_next.last_res  = emit_last;
                out_valid_next     = 1'b1;
                if (emit_last)
                begin
                    count_next = '0;
                    state_next = bhp_pkg::S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = bhp_pkg::S_EM_RD;
                end
            end

            default:
            begin
                state_next = bhp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bhp_pkg::S_IDLE;
            count_reg     <= '0;
            m_reg         <= '0;
            lim_reg       <= '0;
            q_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            m_reg         <= m_next;
            lim_reg       <= lim_next;
            q_reg         <= q_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        diff_reg  <= diff_next;
        delta_reg <= delta_next;
        cand_reg  <= cand_next;
        absc_reg  <= absc_next;
        best_reg  <= best_next;
        av_reg    <= av_next;
        bv_reg    <= bv_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(bhp_pkg::MAX_ITEMS))
        else $error("fill count beyond store depth");

    a_best_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhp_pkg::S_SW_CMP && alu_neg) |=> (best_reg < $past(best_reg)))
        else $error("kept swap did not reduce the best difference");

    a_last_in_b: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_res) |-> result.half)
        else $error("final result not tagged with the second half");

endmodule

// ===== rtl/bhp_store.sv =====
// bhp_store: element memory with one write port and two registered read ports
// depends on bhp_pkg for sizes and the request struct
module bhp_store (
    input  logic                              clk,
    input  bhp_pkg::mem_req_t                 req,
    output logic signed [bhp_pkg::VALUE_W-1:0] rdata0,
    output logic signed [bhp_pkg::VALUE_W-1:0] rdata1
);

    logic signed [bhp_pkg::VALUE_W-1:0] mem [bhp_pkg::MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[req.raddr0];
        rdata1 <= mem[req.raddr1];
    end

endmodule

// ===== rtl/bhp_alu.sv =====
// bhp_alu: the shared add/subtract unit behind every compare, sum and magnitude
// depends on bhp_pkg for the operand struct and width
module bhp_alu (
    input  bhp_pkg::alu_op_t                op,
    output logic signed [bhp_pkg::SUM_W-1:0] sum
);

    logic [bhp_pkg::SUM_W-1:0] b_eff;

    assign b_eff = op.b ^ {bhp_pkg::SUM_W{op.sub}};
    assign sum   = op.a + b_eff + {{(bhp_pkg::SUM_W-1){1'b0}}, op.sub};

endmodule
